// ===== rtl/rc4_stream_cipher_assert.svh =====
// Assertion macros used by the checker file of the RC4 stream cipher.
// Depends on nothing; include by bare file name.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, silenced while reset is high.
`define RC4_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, silenced while reset is high.
`define RC4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rc4_pkg.sv =====
// Shared types and constants of the RC4 stream cipher.
// Depends on nothing; imported by rc4_ctrl, rc4_stream_cipher, rc4_chk and the bench.
package rc4_pkg;

  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KEY_CW = $clog2(MAX_KEY_BYTES + 1);

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_K_RD_I,
    S_K_RD_J,
    S_K_WR_I,
    S_K_WR_J,
    S_D_RD_I,
    S_D_RD_J,
    S_D_WR_I,
    S_D_WR_J
  } state_t;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } perm_port_t;

  typedef struct packed {
    logic              we;
    logic [KEY_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [KEY_AW-1:0] raddr;
  } key_port_t;

endpackage

// ===== rtl/rc4_if.sv =====
// Valid/ready channel interfaces for requests into and results out of the cipher.
// Depends on nothing.
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] value;
  logic       last_key;

  modport source (output valid, command, value, last_key, input ready);
  modport sink (input valid, command, value, last_key, output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink (input valid, out_byte, output ready);
endinterface

// ===== rtl/rc4_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing; used for the permutation table and the key store.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rc4_ctrl.sv =====
// Sequencer of the RC4 cipher: table fill, key schedule and keystream steps.
// Depends on rc4_pkg and rc4_if; drives the ports of both RAMs.
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  rc4_in_if.sink              in,
  rc4_out_if.source           out,
  output perm_port_t          pport,
  input  logic [7:0]          prdata,
  output key_port_t           kport,
  input  logic [7:0]          krdata
);

  state_t            state;
  state_t            state_next;
  logic [7:0]        cnt;
  logic [7:0]        stream_i;
  logic [7:0]        stream_j;
  logic [7:0]        si;
  logic [7:0]        sj;
  logic [7:0]        data_val;
  logic [KEY_AW-1:0] kidx;
  logic [KEY_CW-1:0] key_count;
  logic              out_valid;
  logic              out_valid_next;
  logic [7:0]        out_byte;

  logic              in_acc;
  logic              key_room;
  logic              out_free;
  logic [7:0]        i_inc;
  logic [7:0]        j_data;
  logic [7:0]        acc_next;
  logic [7:0]        t_idx;
  logic [7:0]        ks;
  logic [KEY_CW-1:0] kidx_inc;

  assign in_acc   = in.valid && in.ready;
  assign key_room = key_count < KEY_CW'(MAX_KEY_BYTES);
  assign out_free = !out_valid || out.ready;
  assign i_inc    = stream_i + 8'd1;
  assign j_data   = stream_j + prdata;
  assign acc_next = stream_j + prdata + krdata;
  assign t_idx    = si + sj;
  assign kidx_inc = KEY_CW'(kidx) + KEY_CW'(1);

  // load the result when the last step may finish, drop it once taken
  assign out_valid_next = ((state == S_D_WR_J) && out_free) || (out_valid && !out.ready);

  // Swap writes land after the read of S[t]; take the swapped values instead.
  always_comb begin
    if (t_idx == stream_j) begin
      ks = si;
    end else if (t_idx == stream_i) begin
      ks = sj;
    end else begin
      ks = prdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (cnt == 8'hFF) state_next = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in.command == CMD_DATA) begin
            state_next = S_D_RD_I;
          end else if (in.last_key) begin
            state_next = S_FILL;
          end
        end
      end
      S_FILL:   if (cnt == 8'hFF) state_next = S_K_RD_I;
      S_K_RD_I: state_next = S_K_RD_J;
      S_K_RD_J: state_next = S_K_WR_I;
      S_K_WR_I: state_next = S_K_WR_J;
      S_K_WR_J: state_next = (cnt == 8'hFF) ? S_IDLE : S_K_RD_I;
      S_D_RD_I: state_next = S_D_RD_J;
      S_D_RD_J: state_next = S_D_WR_I;
      S_D_WR_I: state_next = S_D_WR_J;
      S_D_WR_J: if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    pport    = '0;
    kport    = '0;
    in.ready = 1'b0;
    unique case (state)
      S_CLEAR, S_FILL: begin
        pport.we    = 1'b1;
        pport.waddr = cnt;
        pport.wdata = cnt;
      end
      S_IDLE: begin
        in.ready    = 1'b1;
        kport.we    = in.valid && (in.command == CMD_KEY) && key_room;
        kport.waddr = key_count[KEY_AW-1:0];
        kport.wdata = in.value;
      end
      S_K_RD_I: begin
        pport.re    = 1'b1;
        pport.raddr = cnt;
        kport.re    = 1'b1;
        kport.raddr = kidx;
      end
      S_K_RD_J: begin
        pport.re    = 1'b1;
        pport.raddr = acc_next;
      end
      S_K_WR_I: begin
        pport.we    = 1'b1;
        pport.waddr = cnt;
        pport.wdata = prdata;
      end
      S_K_WR_J: begin
        pport.we    = 1'b1;
        pport.waddr = stream_j;
        pport.wdata = si;
      end
      S_D_RD_I: begin
        pport.re    = 1'b1;
        pport.raddr = i_inc;
      end
      S_D_RD_J: begin
        pport.re    = 1'b1;
        pport.raddr = j_data;
      end
      S_D_WR_I: begin
        pport.we    = 1'b1;
        pport.waddr = stream_i;
        pport.wdata = prdata;
        pport.re    = 1'b1;
        pport.raddr = si + prdata;
      end
      S_D_WR_J: begin
        pport.we    = 1'b1;
        pport.waddr = stream_j;
        pport.wdata = si;
      end
      default: begin
        pport = '0;
      end
    endcase
  end

  assign out.valid    = out_valid;
  assign out.out_byte = out_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      stream_i  <= '0;
      stream_j  <= '0;
      key_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      case (state)
        S_CLEAR, S_FILL: cnt <= cnt + 8'd1;
        S_IDLE: begin
          if (in_acc) begin
            data_val <= in.value;
            if (in.command == CMD_KEY) begin
              if (key_room) begin
                key_count <= key_count + KEY_CW'(1);
              end
              if (in.last_key) begin
                cnt      <= '0;
                stream_j <= '0;
                kidx     <= '0;
              end
            end
          end
        end
        S_K_RD_J: begin
          si       <= prdata;
          stream_j <= acc_next;
        end
        S_K_WR_J: begin
          cnt  <= cnt + 8'd1;
          kidx <= (kidx_inc == key_count) ? '0 : kidx_inc[KEY_AW-1:0];
          if (cnt == 8'hFF) begin
            stream_i  <= '0;
            stream_j  <= '0;
            key_count <= '0;
          end
        end
        S_D_RD_I: stream_i <= i_inc;
        S_D_RD_J: begin
          si       <= prdata;
          stream_j <= j_data;
        end
        S_D_WR_I: sj <= prdata;
        S_D_WR_J: begin
          // repeat the second swap write and hold the fetched byte until the result slot frees
          if (out_free) begin
            out_byte <= data_val ^ ks;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher: request and result channels, sequencer and the two RAMs.
// Depends on rc4_pkg, rc4_if, rc4_ram and rc4_ctrl.
//
// Usage: requests arrive on "in" (command, value, last_key) with valid/ready.
// A key request (command 0) stores one key byte on acceptance; bytes past
// the key store size are dropped. A key request with last_key set refills the
// permutation table with the identity and runs the key schedule (256 steps,
// each reading S[i] and the key byte, then S[j], then writing S[i] and S[j]),
// and ready stays low until both are done. The key schedule gives no result.
// A data request (command 1) runs 4 steps after acceptance: two reads, the
// swap writes into the single-write-port permutation RAM and the keystream
// fetch; the result (value XOR keystream byte) is loaded into the output
// register on "out" at the end of the last step. The next request can be
// taken in the cycle after that; no request is taken during those steps.
// After reset the table is filled with the identity in a clearing pass;
// ready is low until it ends. If the receiver stalls, the result holds on
// "out"; the next request is still taken, and it waits in its last step
// until the output register frees.
module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  rc4_in_if.sink    in,
  rc4_out_if.source out
);

  perm_port_t pport;
  key_port_t  kport;
  logic [7:0] prdata;
  logic [7:0] krdata;

  rc4_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .in     (in),
    .out    (out),
    .pport  (pport),
    .prdata (prdata),
    .kport  (kport),
    .krdata (krdata)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(256)) u_perm_ram (
    .clk   (clk),
    .we    (pport.we),
    .waddr (pport.waddr),
    .wdata (pport.wdata),
    .re    (pport.re),
    .raddr (pport.raddr),
    .rdata (prdata)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key_ram (
    .clk   (clk),
    .we    (kport.we),
    .waddr (kport.waddr),
    .wdata (kport.wdata),
    .re    (kport.re),
    .raddr (kport.raddr),
    .rdata (krdata)
  );

endmodule

// ===== rtl/rc4_chk.sv =====
// Port-level checker of the RC4 stream cipher and its bind to the top level.
// Depends on rc4_pkg and rc4_stream_cipher_assert.svh.
`include "rc4_stream_cipher_assert.svh"

module rc4_chk
  import rc4_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte
);

  logic key_acc;
  logic data_acc;
  logic out_stall;

  assign key_acc   = in_valid && in_ready && (in_command == CMD_KEY);
  assign data_acc  = in_valid && in_ready && (in_command == CMD_DATA);
  assign out_stall = out_valid && !out_ready;

  `RC4_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(out_byte), "result changed")
  `RC4_ASSERT_NEXT(a_key_silent, clk, rst, key_acc && !out_valid, !out_valid, "key gave a result")
  `RC4_ASSERT_NEXT(a_one_at_a_time, clk, rst, data_acc, !in_ready, "data request overlapped")

endmodule

bind rc4_stream_cipher rc4_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in.valid),
  .in_ready   (in.ready),
  .in_command (in.command),
  .out_valid  (out.valid),
  .out_ready  (out.ready),
  .out_byte   (out.out_byte)
);

// ===== tb/sv/rc4_stream_cipher_tb.sv =====
// Self-checking bench for rc4_stream_cipher: keys and data bytes go in, and every
// cipher byte that comes out is compared with a byte-level RC4 tracker.
// Depends on rc4_pkg, rc4_if and the RTL of the cipher.
module rc4_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rc4_pkg::*;

  localparam int STALL_LIMIT = 8000;
  localparam int HOLD_CYCLES = 300;
  localparam int REQUEST_TARGET = 1250;

  // Tracks the RC4 state byte for byte and queues the cipher bytes still owed.
  class rc4_cipher_tracker;
    bit [7:0] sbox [256];
    bit [7:0] key_bytes [MAX_KEY_BYTES];
    int unsigned key_len;
    bit [7:0] idx_i;
    bit [7:0] idx_j;
    bit [7:0] cipher_q [$];
    int errors;
    int bytes_seen;

    function new();
      foreach (sbox[n]) sbox[n] = 8'(n);
      key_len = 0;
      idx_i = 0;
      idx_j = 0;
      errors = 0;
      bytes_seen = 0;
    endfunction

    function void swap_bytes(bit [7:0] a, bit [7:0] b);
      bit [7:0] t;
      t = sbox[a];
      sbox[a] = sbox[b];
      sbox[b] = t;
    endfunction

    function void run_key_schedule();
      bit [7:0] acc;
      acc = 0;
      foreach (sbox[n]) sbox[n] = 8'(n);
      for (int n = 0; n < 256; n++) begin
        acc = acc + sbox[n] + key_bytes[n % key_len];
        swap_bytes(8'(n), acc);
      end
      idx_i = 0;
      idx_j = 0;
      key_len = 0;
    endfunction

    function void note_request(logic cmd, bit [7:0] v, logic lk);
      bit [7:0] k;
      if (cmd == CMD_KEY) begin
        // drop key bytes once the store is full, but still honour the last flag
        if (key_len < MAX_KEY_BYTES) begin
          key_bytes[key_len] = v;
          key_len++;
        end
        if (lk) run_key_schedule();
      end else begin
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox[idx_i];
        swap_bytes(idx_i, idx_j);
        k = sbox[idx_i] + sbox[idx_j];
        cipher_q = {cipher_q, 8'(v ^ sbox[k])};
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] %s", $time, msg);
    endtask

    task check_byte(bit [7:0] got);
      bit [7:0] want;
      bytes_seen++;
      if (cipher_q.size() == 0) begin
        report($sformatf("out_byte 0x%02h with no data request outstanding", got));
      end else begin
        want = cipher_q.pop_front();
        if (got !== want)
          report($sformatf("out_byte 0x%02h, should be 0x%02h (byte %0d)",
                           got, want, bytes_seen));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  rc4_in_if  in_ch();
  rc4_out_if out_ch();

  rc4_stream_cipher uut (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch)
  );

  rc4_cipher_tracker tracker = new();
  int requests_sent = 0;
  bit steady = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic cmd, logic [7:0] v, logic lk);
    if (!steady) begin
      while ($urandom_range(0, 99) < 11) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.value    <= v;
    in_ch.last_key <= lk;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_request(cmd, v, lk);
    requests_sent++;
    // no random idling on either side for a stretch in the middle of the run
    steady = (requests_sent >= 500) && (requests_sent < 800);
    @(negedge clk);
  endtask

  task automatic send_key(int len);
    for (int n = 0; n < len; n++)
      send_request(CMD_KEY, 8'($urandom), n == len - 1);
  endtask

  task automatic send_data(int count);
    for (int n = 0; n < count; n++)
      send_request(CMD_DATA, 8'($urandom), 1'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_KEY;
    in_ch.value = 8'h00;
    in_ch.last_key = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // keystream straight from the reset state, last flag on data ignored
    send_request(CMD_DATA, 8'h00, 1'b0);
    send_request(CMD_DATA, 8'hFF, 1'b0);
    send_request(CMD_DATA, 8'h5A, 1'b1);
    // single-byte key
    send_request(CMD_KEY, 8'h00, 1'b1);
    send_request(CMD_DATA, 8'hFF, 1'b0);
    send_request(CMD_DATA, 8'h00, 1'b0);
    send_request(CMD_KEY, 8'hFF, 1'b0);
    send_request(CMD_KEY, 8'h80, 1'b0);
    send_request(CMD_KEY, 8'h01, 1'b1);
    send_request(CMD_DATA, 8'hAA, 1'b1);
    send_request(CMD_DATA, 8'h55, 1'b0);
    send_request(CMD_DATA, 8'h01, 1'b0);
    send_request(CMD_KEY, 8'h7F, 1'b1);
    send_request(CMD_DATA, 8'h80, 1'b0);

    // full key store, then a key that overflows with the last flag on a dropped byte
    send_key(MAX_KEY_BYTES);
    send_data(8);
    send_key($urandom_range(MAX_KEY_BYTES + 1, MAX_KEY_BYTES + 40));
    send_data(8);

    while (requests_sent < REQUEST_TARGET) begin
      if ($urandom_range(0, 99) < 85) begin
        send_key(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16));
        send_data($urandom_range(4, 40));
      end else begin
        send_request(1'($urandom), 8'($urandom), 1'($urandom));
      end
    end
    in_ch.valid <= 1'b0;

    while (tracker.cipher_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0)
      $display("** rc4_stream_cipher: PASSED **");
    else
      $display("** rc4_stream_cipher: FAILED **");
    $finish;
  end

  initial begin : result_sink
    int hold_left;
    int next_hold;
    hold_left = 0;
    next_hold = 120;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      // hold off for a long stretch so the cipher fills up and stalls requests
      if (hold_left == 0 && tracker.bytes_seen == next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold += 480;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 11);
      end
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        tracker.check_byte(out_ch.out_byte);
    end
  end

  initial begin : stall_watch
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
    $display("** rc4_stream_cipher: FAILED **");
    $finish;
  end

endmodule
